// File: rtl/bfd_pkg.sv
// shared constants and beat types for the 2x2 box filter downscaler
`default_nettype none

package bfd_pkg;

    // widest source row the line store is sized for
    localparam int MAX_WIDTH   = 4096;
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int LINE_AW     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int COL_W       = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int EFF_W       = $clog2(MAX_WIDTH + 1);

    localparam int SRC_WIDTH_W  = 13;
    localparam int SRC_HEIGHT_W = 16;
    localparam int CMP_W        = (SRC_WIDTH_W > EFF_W) ? SRC_WIDTH_W : EFF_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'd1;

    localparam logic [SRC_WIDTH_W-1:0]  SOURCE_WIDTH_RST  = 13'd640;
    localparam logic [SRC_HEIGHT_W-1:0] SOURCE_HEIGHT_RST = 16'd480;

    localparam int NUM_CHAN = 4;
    localparam int CHAN_W   = 8;
    localparam int SUM_W    = CHAN_W + 1;
    localparam int LINE_W   = NUM_CHAN * SUM_W;

    typedef struct packed {
        logic [CHAN_W-1:0] in_red;
        logic [CHAN_W-1:0] in_green;
        logic [CHAN_W-1:0] in_blue;
        logic [CHAN_W-1:0] in_alpha;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_alpha;
        logic              frame_end;
    } block_t;

endpackage

`default_nettype wire

// File: rtl/bfd_line_ram.sv
// single-port-write, single-port-read line store with registered read data
`default_nettype none

module bfd_line_ram #(
    parameter int DEPTH  = 2048,
    parameter int DATA_W = 36,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/bfd_lane.sv
// one color channel: horizontal pair sum and 2x2 truncated average
`default_nettype none

module bfd_lane
    import bfd_pkg::*;
(
    input  wire logic [CHAN_W-1:0] held,
    input  wire logic [CHAN_W-1:0] pixel,
    input  wire logic [SUM_W-1:0]  upper_sum,
    input  wire logic [SUM_W-1:0]  lower_sum,
    output      logic [SUM_W-1:0]  pair_sum,
    output      logic [CHAN_W-1:0] average
);

    logic [SUM_W:0] block_sum;

    assign pair_sum  = {1'b0, held} + {1'b0, pixel};
    assign block_sum = {1'b0, upper_sum} + {1'b0, lower_sum};
    // divide by four, truncated
    assign average   = block_sum[SUM_W:2];

endmodule

`default_nettype wire

// File: rtl/box_filter_downscale_2x.sv
// top level of the rgba 2x2 box filter downscaler
`default_nettype none

// Halves an RGBA8 raster frame in both directions: each block beat is the
// per-channel truncated average of a 2x2 pixel block, with frame_end set on
// the last block of the frame. One pixel beat is taken every clock while
// pixel_stall is low; a block beat passes through the line store read and
// the stage 1 register, then the output register. The line store does one
// access per column pair, on its odd column: a write of the pair sum on even
// rows, a read on odd rows.
// It has no clearing pass and is usable right after reset. An odd last column
// or row is consumed without output. source_width and source_height should
// only be written while the block is idle.

module box_filter_downscale_2x
    import bfd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   pixel_valid,
    output      logic                   pixel_stall,
    input  wire pixel_t                 pixel_data,

    output      logic                   block_valid,
    input  wire logic                   block_stall,
    output      block_t                 block_data
);

    // configuration
    logic [SRC_WIDTH_W-1:0]  width_reg;
    logic [SRC_HEIGHT_W-1:0] height_reg;

    // position in the frame
    logic [COL_W-1:0]        col_reg, col_next;
    logic [SRC_HEIGHT_W-1:0] row_reg, row_next;

    // even-column pixel kept for its pair
    logic [CHAN_W-1:0] held_reg [NUM_CHAN];
    logic [CHAN_W-1:0] pixel_ch [NUM_CHAN];

    // stage 1: waiting on the line store read
    logic              s1_valid_reg, s1_valid_next;
    logic [LINE_W-1:0] s1_pair_reg;
    logic              s1_last_reg;

    // output register
    logic   out_valid_reg, out_valid_next;
    block_t out_data_reg;

    logic [LINE_W-1:0] pair_line;
    logic [LINE_W-1:0] upper_line;
    logic [CHAN_W-1:0] avg_ch [NUM_CHAN];

    // effective width and height
    logic [CMP_W-1:0]        w_cmp;
    logic [EFF_W-1:0]        eff_w;
    logic [SRC_HEIGHT_W-1:0] eff_h;

    logic [EFF_W:0]          col_ext, col_inc, w_ext, w_pair_end;
    logic [SRC_HEIGHT_W:0]   row_inc, h_ext, h_pair_end;
    logic [COL_W-1:0]        pair_idx;
    logic [LINE_AW-1:0]      line_addr;

    logic row_done, frame_done, col_in_range, row_in_range;
    logic idx_ok, pair_op, produce, last_block;
    logic accept, out_free, s1_move;
    logic wr_en, rd_en;

    // handshake: s1 may hand over to the output register while a new pixel lands
    assign out_free    = !out_valid_reg || !block_stall;
    assign s1_move     = s1_valid_reg && out_free;
    assign pixel_stall = s1_valid_reg && !out_free;
    assign accept      = pixel_valid && !pixel_stall;

    assign block_valid = out_valid_reg;
    assign block_data  = out_data_reg;

    // zero width or height counts as one, widths past the line store saturate
    always_comb
    begin
        w_cmp = CMP_W'(width_reg);
        if (w_cmp == '0)
        begin
            w_cmp = CMP_W'(1);
        end
        else if (w_cmp > CMP_W'(MAX_WIDTH))
        begin
            w_cmp = CMP_W'(MAX_WIDTH);
        end
        eff_w = EFF_W'(w_cmp);
        eff_h = (height_reg == '0) ? SRC_HEIGHT_W'(1) : height_reg;
    end

    assign col_ext      = {1'b0, EFF_W'(col_reg)};
    assign col_inc      = col_ext + (EFF_W + 1)'(1);
    assign w_ext        = {1'b0, eff_w};
    assign w_pair_end   = {1'b0, eff_w[EFF_W-1:1], 1'b0};
    assign row_inc      = {1'b0, row_reg} + (SRC_HEIGHT_W + 1)'(1);
    assign h_ext        = {1'b0, eff_h};
    assign h_pair_end   = {1'b0, eff_h[SRC_HEIGHT_W-1:1], 1'b0};

    assign row_done     = col_inc >= w_ext;
    assign frame_done   = row_inc >= h_ext;
    assign col_in_range = col_ext < w_ext;
    assign row_in_range = row_reg < eff_h;

    assign pair_idx     = col_reg >> 1;
    assign idx_ok       = pair_idx < COL_W'(LINE_DEPTH);
    assign line_addr    = LINE_AW'(pair_idx);

    // odd column closing a pair
    assign pair_op      = col_reg[0] && col_in_range && idx_ok;
    assign produce      = pair_op && row_reg[0] && row_in_range;
    assign last_block   = (col_inc == w_pair_end) && (row_inc == h_pair_end);

    assign wr_en        = accept && pair_op && !row_reg[0];
    assign rd_en        = accept && produce;

    // channel lanes
    assign pixel_ch[0] = pixel_data.in_red;
    assign pixel_ch[1] = pixel_data.in_green;
    assign pixel_ch[2] = pixel_data.in_blue;
    assign pixel_ch[3] = pixel_data.in_alpha;

    for (genvar g = 0; g < NUM_CHAN; g++)
    begin : g_lane
        bfd_lane u_lane (
            .held      (held_reg[g]),
            .pixel     (pixel_ch[g]),
            .upper_sum (upper_line[g*SUM_W +: SUM_W]),
            .lower_sum (s1_pair_reg[g*SUM_W +: SUM_W]),
            .pair_sum  (pair_line[g*SUM_W +: SUM_W]),
            .average   (avg_ch[g])
        );
    end

    bfd_line_ram #(
        .DEPTH  (LINE_DEPTH),
        .DATA_W (LINE_W),
        .ADDR_W (LINE_AW)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (line_addr),
        .wr_data (pair_line),
        .rd_en   (rd_en),
        .rd_addr (line_addr),
        .rd_data (upper_line)
    );

    // counters
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (row_done)
            begin
                col_next = '0;
                row_next = frame_done ? '0 : row_inc[SRC_HEIGHT_W-1:0];
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
    end

    // pipeline valids
    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = produce;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        out_valid_next = s1_move || (out_valid_reg && block_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= SOURCE_WIDTH_RST;
            height_reg    <= SOURCE_HEIGHT_RST;
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SOURCE_WIDTH:  width_reg  <= cfg_data[SRC_WIDTH_W-1:0];
                    REG_SOURCE_HEIGHT: height_reg <= cfg_data[SRC_HEIGHT_W-1:0];
                    default:           ;
                endcase
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept && !col_reg[0])
        begin
            for (int c = 0; c < NUM_CHAN; c++)
            begin
                held_reg[c] <= pixel_ch[c];
            end
        end
        if (accept && produce)
        begin
            s1_pair_reg <= pair_line;
            s1_last_reg <= last_block;
        end
        // merge the lane averages into one block beat
        if (s1_move)
        begin
            out_data_reg.out_red   <= avg_ch[0];
            out_data_reg.out_green <= avg_ch[1];
            out_data_reg.out_blue  <= avg_ch[2];
            out_data_reg.out_alpha <= avg_ch[3];
            out_data_reg.frame_end <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire
